FILE: rtl/core/mie_pkg.sv
package mie_pkg;

    localparam logic [5:0] OP_J      = 6'd2;
    localparam logic [5:0] OP_JAL    = 6'd3;
    localparam logic [5:0] OP_BEQ    = 6'd4;
    localparam logic [5:0] OP_BNE    = 6'd5;
    localparam logic [5:0] OP_BLEZ   = 6'd6;
    localparam logic [5:0] OP_BGTZ   = 6'd7;
    localparam logic [5:0] OP_ADDI   = 6'd8;
    localparam logic [5:0] OP_ADDIU  = 6'd9;
    localparam logic [5:0] OP_SLTI   = 6'd10;
    localparam logic [5:0] OP_SLTIU  = 6'd11;
    localparam logic [5:0] OP_ANDI   = 6'd12;
    localparam logic [5:0] OP_ORI    = 6'd13;
    localparam logic [5:0] OP_XORI   = 6'd14;
    localparam logic [5:0] OP_LUI    = 6'd15;
    localparam logic [5:0] OP_BEQL   = 6'd20;
    localparam logic [5:0] OP_BNEL   = 6'd21;
    localparam logic [5:0] OP_BLEZL  = 6'd22;
    localparam logic [5:0] OP_BGTZL  = 6'd23;
    localparam logic [5:0] OP_DADDI  = 6'd24;
    localparam logic [5:0] OP_DADDIU = 6'd25;
    localparam logic [5:0] OP_LB     = 6'd32;
    localparam logic [5:0] OP_LH     = 6'd33;
    localparam logic [5:0] OP_LWL    = 6'd34;
    localparam logic [5:0] OP_LW     = 6'd35;
    localparam logic [5:0] OP_LBU    = 6'd36;
    localparam logic [5:0] OP_LHU    = 6'd37;
    localparam logic [5:0] OP_LWR    = 6'd38;
    localparam logic [5:0] OP_LWU    = 6'd39;
    localparam logic [5:0] OP_SB     = 6'd40;
    localparam logic [5:0] OP_SH     = 6'd41;
    localparam logic [5:0] OP_SWL    = 6'd42;
    localparam logic [5:0] OP_SW     = 6'd43;
    localparam logic [5:0] OP_SWR    = 6'd46;
    localparam logic [5:0] OP_LD     = 6'd55;
    localparam logic [5:0] OP_SD     = 6'd63;

    localparam logic [4:0] LINK_REG = 5'd31;

    localparam logic [1:0] ACC_BYTE = 2'd0;
    localparam logic [1:0] ACC_HALF = 2'd1;
    localparam logic [1:0] ACC_WORD = 2'd2;
    localparam logic [1:0] ACC_DBL  = 2'd3;

    localparam logic [31:0] SEG_MASK = 32'hF000_0000;

    typedef struct packed {
        logic [5:0]         opcode;
        logic [4:0]         rt_index;
        logic [15:0]        immediate;
        logic [25:0]        jump_index;
        logic [31:0]        pc;
        logic signed [63:0] rs_value;
        logic signed [63:0] rt_value;
        logic [63:0]        mem_data;
    } t_in_beat;

    typedef struct packed {
        logic signed [63:0] wb_value;
        logic               wb_enable;
        logic [4:0]         wb_index;
        logic [31:0]        mem_address;
        logic [1:0]         access_size;
        logic               mem_read;
        logic               mem_write;
        logic [63:0]        store_data;
        logic               branch_taken;
        logic [31:0]        next_pc;
        logic               nullify_delay_slot;
        logic               unsupported;
    } t_out_beat;

    typedef struct packed {
        logic [5:0]  opcode;
        logic [4:0]  rt_index;
        logic [15:0] immediate;
        logic [25:0] jump_index;
        logic [31:0] pc4;
        logic [31:0] pc8;
        logic [31:0] btarget;
        logic [63:0] rs_value;
        logic [63:0] rt_value;
        logic [63:0] mem_data;
        logic [63:0] sum;
        logic        rs_eq_rt;
    } t_stage1;

    typedef struct packed {
        logic [5:0]  opcode;
        logic [4:0]  rt_index;
        logic [15:0] immediate;
        logic [25:0] jump_index;
        logic [31:0] pc4;
        logic [31:0] pc8;
        logic [31:0] btarget;
        logic [63:0] rs_value;
        logic [63:0] sum;
        logic [63:0] load_value;
        logic [63:0] store_value;
        logic        lt_signed;
        logic        lt_unsigned;
        logic        cond;
    } t_stage2;

    function automatic logic [63:0] sext32(input logic [31:0] w);
        return {{32{w[31]}}, w};
    endfunction

    function automatic logic [31:0] lwl_keep(input logic [1:0] off);
        logic [31:0] m;
        case (off)
            2'd0:    m = 32'h0000_0000;
            2'd1:    m = 32'h0000_00FF;
            2'd2:    m = 32'h0000_FFFF;
            default: m = 32'h00FF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] lwr_keep(input logic [1:0] off);
        logic [31:0] m;
        case (off)
            2'd0:    m = 32'hFFFF_FF00;
            2'd1:    m = 32'hFFFF_0000;
            2'd2:    m = 32'hFF00_0000;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] swl_keep(input logic [1:0] off);
        logic [31:0] m;
        case (off)
            2'd0:    m = 32'h0000_0000;
            2'd1:    m = 32'hFF00_0000;
            2'd2:    m = 32'hFFFF_0000;
            default: m = 32'hFFFF_FF00;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] swr_keep(input logic [1:0] off);
        logic [31:0] m;
        case (off)
            2'd0:    m = 32'h00FF_FFFF;
            2'd1:    m = 32'h0000_FFFF;
            2'd2:    m = 32'h0000_00FF;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/mie_issue_if.sv
interface mie_issue_if import mie_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/mie_result_if.sv
interface mie_result_if import mie_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/mie_mem_merge.sv
module mie_mem_merge import mie_pkg::*; (
    input  logic [5:0]  i_opcode,
    input  logic [63:0] i_mem_data,
    input  logic [63:0] i_rt_value,
    input  logic [1:0]  i_offset,
    output logic [63:0] o_load_value,
    output logic [63:0] o_store_value
);

    logic [31:0] mw;
    logic [31:0] rw;
    logic [4:0]  sh_left;
    logic [4:0]  sh_right;

    assign mw       = i_mem_data[31:0];
    assign rw       = i_rt_value[31:0];
    assign sh_left  = {i_offset, 3'b000};
    assign sh_right = {~i_offset, 3'b000};

    always_comb begin
        case (i_opcode)
            OP_LB:   o_load_value = {{56{i_mem_data[7]}}, i_mem_data[7:0]};
            OP_LBU:  o_load_value = {56'd0, i_mem_data[7:0]};
            OP_LH:   o_load_value = {{48{i_mem_data[15]}}, i_mem_data[15:0]};
            OP_LHU:  o_load_value = {48'd0, i_mem_data[15:0]};
            OP_LW:   o_load_value = sext32(mw);
            OP_LWU:  o_load_value = {32'd0, mw};
            OP_LD:   o_load_value = i_mem_data;
            OP_LWL:  o_load_value = sext32((mw << sh_left) | (rw & lwl_keep(i_offset)));
            OP_LWR:  o_load_value = sext32((mw >> sh_right) | (rw & lwr_keep(i_offset)));
            default: o_load_value = 64'd0;
        endcase
    end

    always_comb begin
        case (i_opcode)
            OP_SB:   o_store_value = {56'd0, i_rt_value[7:0]};
            OP_SH:   o_store_value = {48'd0, i_rt_value[15:0]};
            OP_SW:   o_store_value = {32'd0, rw};
            OP_SD:   o_store_value = i_rt_value;
            OP_SWL:  o_store_value = {32'd0, (mw & swl_keep(i_offset)) | (rw >> sh_left)};
            OP_SWR:  o_store_value = {32'd0, (mw & swr_keep(i_offset)) | (rw << sh_right)};
            default: o_store_value = 64'd0;
        endcase
    end

endmodule

FILE: rtl/core/mips64_itype_execute.sv
// An issue beat goes to r_s1, then r_s2, then r_s3, which drives the result beat.
// Throughput: one instruction per cycle unless o_result stalls; three register
// stages, each with a valid bit; a stage moves when the next is empty or moving.
// Reset clears the valid bits only; payload registers are not reset.
module mips64_itype_execute import mie_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mie_issue_if.sink     i_issue,
    mie_result_if.source  o_result
);

    logic      r_v1, r_v2, r_v3;
    t_stage1   r_s1, n_s1;
    t_stage2   r_s2, n_s2;
    t_out_beat r_s3, n_s3;
    logic      adv1, adv2, adv3;
    logic [63:0] simm;
    logic [63:0] load_value;
    logic [63:0] store_value;

    assign adv3 = !r_v3 || o_result.ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign i_issue.ready  = adv1;
    assign o_result.valid = r_v3;
    assign o_result.data  = r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_issue.valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) r_s1 <= n_s1;
        if (adv2) r_s2 <= n_s2;
        if (adv3) r_s3 <= n_s3;
    end

    // stage 1: address add, compare, pc arithmetic
    assign simm = {{48{i_issue.data.immediate[15]}}, i_issue.data.immediate};

    always_comb begin
        n_s1.opcode     = i_issue.data.opcode;
        n_s1.rt_index   = i_issue.data.rt_index;
        n_s1.immediate  = i_issue.data.immediate;
        n_s1.jump_index = i_issue.data.jump_index;
        n_s1.pc4        = i_issue.data.pc + 32'd4;
        n_s1.pc8        = i_issue.data.pc + 32'd8;
        n_s1.btarget    = i_issue.data.pc + 32'd4 + {simm[29:0], 2'b00};
        n_s1.rs_value   = i_issue.data.rs_value;
        n_s1.rt_value   = i_issue.data.rt_value;
        n_s1.mem_data   = i_issue.data.mem_data;
        n_s1.sum        = i_issue.data.rs_value + simm;
        n_s1.rs_eq_rt   = i_issue.data.rs_value == i_issue.data.rt_value;
    end

    // stage 2: load extension, unaligned merges, set-less-than, branch condition
    mie_mem_merge u_merge (
        .i_opcode      (r_s1.opcode),
        .i_mem_data    (r_s1.mem_data),
        .i_rt_value    (r_s1.rt_value),
        .i_offset      (r_s1.sum[1:0]),
        .o_load_value  (load_value),
        .o_store_value (store_value)
    );

    always_comb begin
        logic [63:0] simm1;
        simm1 = {{48{r_s1.immediate[15]}}, r_s1.immediate};
        n_s2.opcode      = r_s1.opcode;
        n_s2.rt_index    = r_s1.rt_index;
        n_s2.immediate   = r_s1.immediate;
        n_s2.jump_index  = r_s1.jump_index;
        n_s2.pc4         = r_s1.pc4;
        n_s2.pc8         = r_s1.pc8;
        n_s2.btarget     = r_s1.btarget;
        n_s2.rs_value    = r_s1.rs_value;
        n_s2.sum         = r_s1.sum;
        n_s2.load_value  = load_value;
        n_s2.store_value = store_value;
        n_s2.lt_signed   = $signed(r_s1.rs_value) < $signed(simm1);
        n_s2.lt_unsigned = r_s1.rs_value < simm1;
        case (r_s1.opcode)
            OP_BEQ, OP_BEQL:   n_s2.cond = r_s1.rs_eq_rt;
            OP_BNE, OP_BNEL:   n_s2.cond = !r_s1.rs_eq_rt;
            OP_BLEZ, OP_BLEZL: n_s2.cond = (r_s1.rs_value == 64'd0) || r_s1.rs_value[63];
            OP_BGTZ, OP_BGTZL: n_s2.cond = (r_s1.rs_value != 64'd0) && !r_s1.rs_value[63];
            default:           n_s2.cond = 1'b0;
        endcase
    end

    // stage 3: decode and select the result beat
    always_comb begin
        logic [63:0] wv;
        logic [4:0]  dest;
        logic [31:0] ea;
        logic [31:0] al;
        ea   = r_s2.sum[31:0];
        al   = {ea[31:2], 2'b00};
        wv   = 64'd0;
        dest = 5'd0;
        n_s3 = '0;
        n_s3.next_pc = r_s2.pc4;
        case (r_s2.opcode)
            OP_J, OP_JAL: begin
                n_s3.branch_taken = 1'b1;
                n_s3.next_pc = {r_s2.pc4[31:28], r_s2.jump_index, 2'b00};
                if (r_s2.opcode == OP_JAL) begin
                    dest = LINK_REG;
                    wv   = sext32(r_s2.pc8);
                end
            end
            OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
            OP_BEQL, OP_BNEL, OP_BLEZL, OP_BGTZL: begin
                n_s3.branch_taken = r_s2.cond;
                n_s3.next_pc = r_s2.cond ? r_s2.btarget : r_s2.pc8;
                n_s3.nullify_delay_slot = !r_s2.cond &&
                    (r_s2.opcode == OP_BEQL || r_s2.opcode == OP_BNEL ||
                     r_s2.opcode == OP_BLEZL || r_s2.opcode == OP_BGTZL);
            end
            OP_ADDI, OP_ADDIU: begin
                dest = r_s2.rt_index;
                wv   = sext32(r_s2.sum[31:0]);
            end
            OP_DADDI, OP_DADDIU: begin
                dest = r_s2.rt_index;
                wv   = r_s2.sum;
            end
            OP_SLTI: begin
                dest = r_s2.rt_index;
                wv   = {63'd0, r_s2.lt_signed};
            end
            OP_SLTIU: begin
                dest = r_s2.rt_index;
                wv   = {63'd0, r_s2.lt_unsigned};
            end
            OP_ANDI: begin
                dest = r_s2.rt_index;
                wv   = r_s2.rs_value & {48'd0, r_s2.immediate};
            end
            OP_ORI: begin
                dest = r_s2.rt_index;
                wv   = r_s2.rs_value | {48'd0, r_s2.immediate};
            end
            OP_XORI: begin
                dest = r_s2.rt_index;
                wv   = r_s2.rs_value ^ {48'd0, r_s2.immediate};
            end
            OP_LUI: begin
                dest = r_s2.rt_index;
                wv   = sext32({r_s2.immediate, 16'd0});
            end
            OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LWU, OP_LD: begin
                dest = r_s2.rt_index;
                wv   = r_s2.load_value;
                n_s3.mem_read    = 1'b1;
                n_s3.mem_address = ea;
                case (r_s2.opcode)
                    OP_LB, OP_LBU: n_s3.access_size = ACC_BYTE;
                    OP_LH, OP_LHU: n_s3.access_size = ACC_HALF;
                    OP_LD:         n_s3.access_size = ACC_DBL;
                    default:       n_s3.access_size = ACC_WORD;
                endcase
            end
            OP_LWL, OP_LWR: begin
                dest = r_s2.rt_index;
                wv   = r_s2.load_value;
                n_s3.mem_read    = 1'b1;
                n_s3.mem_address = al;
                n_s3.access_size = ACC_WORD;
            end
            OP_SB, OP_SH, OP_SW, OP_SD: begin
                n_s3.mem_write   = 1'b1;
                n_s3.mem_address = ea;
                n_s3.store_data  = r_s2.store_value;
                case (r_s2.opcode)
                    OP_SB:   n_s3.access_size = ACC_BYTE;
                    OP_SH:   n_s3.access_size = ACC_HALF;
                    OP_SD:   n_s3.access_size = ACC_DBL;
                    default: n_s3.access_size = ACC_WORD;
                endcase
            end
            OP_SWL, OP_SWR: begin
                n_s3.mem_read    = 1'b1;
                n_s3.mem_write   = 1'b1;
                n_s3.mem_address = al;
                n_s3.access_size = ACC_WORD;
                n_s3.store_data  = r_s2.store_value;
            end
            default: begin
                n_s3.unsupported = 1'b1;
            end
        endcase
        // drop writes to register zero
        n_s3.wb_enable = dest != 5'd0;
        n_s3.wb_index  = dest;
        n_s3.wb_value  = (dest != 5'd0) ? wv : 64'd0;
    end

endmodule

FILE: bench/tb_mips64_itype_execute.sv
`timescale 1ns / 1ps

module tb_mips64_itype_execute;
    import mie_pkg::*;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_REGIMM  = 6'd1;
    localparam logic [5:0] OP_LDL     = 6'd26;
    localparam logic [5:0] OP_CACHE   = 6'd47;

    localparam logic [5:0] KNOWN_OPS [0:34] = '{
        OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
        OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
        OP_BEQL, OP_BNEL, OP_BLEZL, OP_BGTZL, OP_DADDI, OP_DADDIU,
        OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR, OP_LWU,
        OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR, OP_LD, OP_SD
    };

    localparam int unsigned RANDOM_INSTRS = 1600;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    class itype_scoreboard;
        t_out_beat   pending_results[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function t_out_beat execute_instr(t_in_beat b);
            logic [63:0] rs, rtv, md, simm, wv, sd, keep;
            logic [31:0] ea, al, pc4, pc8, btarget, mw, rw, npc, addr, merged;
            logic [1:0]  off, size;
            logic [4:0]  dest;
            logic        rd, wr, taken, nul, uns, cond, likely, branch;
            t_out_beat   r;

            rs      = b.rs_value;
            rtv     = b.rt_value;
            md      = b.mem_data;
            simm    = {{48{b.immediate[15]}}, b.immediate};
            ea      = rs[31:0] + simm[31:0];
            off     = ea[1:0];
            al      = {ea[31:2], 2'b00};
            pc4     = b.pc + 32'd4;
            pc8     = b.pc + 32'd8;
            btarget = pc4 + {simm[29:0], 2'b00};
            mw      = md[31:0];
            rw      = rtv[31:0];
            wv      = '0;
            sd      = '0;
            keep    = '0;
            merged  = '0;
            dest    = '0;
            addr    = '0;
            size    = ACC_BYTE;
            npc     = pc4;
            rd      = 1'b0;
            wr      = 1'b0;
            taken   = 1'b0;
            nul     = 1'b0;
            uns     = 1'b0;
            cond    = 1'b0;
            likely  = 1'b0;
            branch  = 1'b0;

            case (b.opcode)
                OP_J, OP_JAL: begin
                    taken = 1'b1;
                    npc   = {pc4[31:28], b.jump_index, 2'b00};
                    if (b.opcode == OP_JAL) begin
                        dest = LINK_REG;
                        wv   = {{32{pc8[31]}}, pc8};
                    end
                end
                OP_BEQ, OP_BEQL: begin
                    branch = 1'b1;
                    cond   = (rs == rtv);
                    likely = (b.opcode == OP_BEQL);
                end
                OP_BNE, OP_BNEL: begin
                    branch = 1'b1;
                    cond   = (rs != rtv);
                    likely = (b.opcode == OP_BNEL);
                end
                OP_BLEZ, OP_BLEZL: begin
                    branch = 1'b1;
                    cond   = (rs == 64'd0) || rs[63];
                    likely = (b.opcode == OP_BLEZL);
                end
                OP_BGTZ, OP_BGTZL: begin
                    branch = 1'b1;
                    cond   = (rs != 64'd0) && !rs[63];
                    likely = (b.opcode == OP_BGTZL);
                end
                OP_ADDI, OP_ADDIU: begin
                    dest = b.rt_index;
                    wv   = {{32{ea[31]}}, ea};
                end
                OP_DADDI, OP_DADDIU: begin
                    dest = b.rt_index;
                    wv   = rs + simm;
                end
                OP_SLTI: begin
                    dest = b.rt_index;
                    wv   = {63'd0, $signed(rs) < $signed(simm)};
                end
                OP_SLTIU: begin
                    dest = b.rt_index;
                    wv   = {63'd0, rs < simm};
                end
                OP_ANDI: begin
                    dest = b.rt_index;
                    wv   = rs & {48'd0, b.immediate};
                end
                OP_ORI: begin
                    dest = b.rt_index;
                    wv   = rs | {48'd0, b.immediate};
                end
                OP_XORI: begin
                    dest = b.rt_index;
                    wv   = rs ^ {48'd0, b.immediate};
                end
                OP_LUI: begin
                    dest = b.rt_index;
                    wv   = {{32{b.immediate[15]}}, b.immediate, 16'd0};
                end
                OP_LB, OP_LBU: begin
                    rd   = 1'b1;
                    addr = ea;
                    size = ACC_BYTE;
                    dest = b.rt_index;
                    wv   = {{56{md[7] && b.opcode == OP_LB}}, md[7:0]};
                end
                OP_LH, OP_LHU: begin
                    rd   = 1'b1;
                    addr = ea;
                    size = ACC_HALF;
                    dest = b.rt_index;
                    wv   = {{48{md[15] && b.opcode == OP_LH}}, md[15:0]};
                end
                OP_LW, OP_LWU: begin
                    rd   = 1'b1;
                    addr = ea;
                    size = ACC_WORD;
                    dest = b.rt_index;
                    wv   = {{32{mw[31] && b.opcode == OP_LW}}, mw};
                end
                OP_LD: begin
                    rd   = 1'b1;
                    addr = ea;
                    size = ACC_DBL;
                    dest = b.rt_index;
                    wv   = md;
                end
                OP_LWL: begin
                    rd     = 1'b1;
                    addr   = al;
                    size   = ACC_WORD;
                    dest   = b.rt_index;
                    keep   = (64'd1 << {off, 3'b000}) - 64'd1;
                    merged = (mw << {off, 3'b000}) | (rw & keep[31:0]);
                    wv     = {{32{merged[31]}}, merged};
                end
                OP_LWR: begin
                    rd     = 1'b1;
                    addr   = al;
                    size   = ACC_WORD;
                    dest   = b.rt_index;
                    keep   = ~((64'd1 << ({off, 3'b000} + 6'd8)) - 64'd1);
                    merged = (mw >> {~off, 3'b000}) | (rw & keep[31:0]);
                    wv     = {{32{merged[31]}}, merged};
                end
                OP_SB: begin
                    wr   = 1'b1;
                    addr = ea;
                    size = ACC_BYTE;
                    sd   = {56'd0, rtv[7:0]};
                end
                OP_SH: begin
                    wr   = 1'b1;
                    addr = ea;
                    size = ACC_HALF;
                    sd   = {48'd0, rtv[15:0]};
                end
                OP_SW: begin
                    wr   = 1'b1;
                    addr = ea;
                    size = ACC_WORD;
                    sd   = {32'd0, rw};
                end
                OP_SD: begin
                    wr   = 1'b1;
                    addr = ea;
                    size = ACC_DBL;
                    sd   = rtv;
                end
                OP_SWL: begin
                    rd     = 1'b1;
                    wr     = 1'b1;
                    addr   = al;
                    size   = ACC_WORD;
                    keep   = ~(64'h0000_0000_FFFF_FFFF >> {off, 3'b000});
                    merged = (mw & keep[31:0]) | (rw >> {off, 3'b000});
                    sd     = {32'd0, merged};
                end
                OP_SWR: begin
                    rd     = 1'b1;
                    wr     = 1'b1;
                    addr   = al;
                    size   = ACC_WORD;
                    keep   = 64'h0000_0000_FFFF_FFFF >> ({off, 3'b000} + 6'd8);
                    merged = (mw & keep[31:0]) | (rw << {~off, 3'b000});
                    sd     = {32'd0, merged};
                end
                default: begin
                    uns = 1'b1;
                end
            endcase

            if (branch) begin
                taken = cond;
                npc   = cond ? btarget : pc8;
                nul   = likely && !cond;
            end
            if (dest == 5'd0) begin
                wv = '0;
            end

            r.wb_value           = wv;
            r.wb_enable          = (dest != 5'd0);
            r.wb_index           = dest;
            r.mem_address        = addr;
            r.access_size        = size;
            r.mem_read           = rd;
            r.mem_write          = wr;
            r.store_data         = sd;
            r.branch_taken       = taken;
            r.next_pc            = npc;
            r.nullify_delay_slot = nul;
            r.unsupported        = uns;
            return r;
        endfunction

        function void note_issue(t_in_beat b);
            pending_results.push_back(execute_instr(b));
        endfunction

        function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
            if (exp !== act) begin
                mismatches++;
                $display("%0t: %s expected %h actual %h", $time, name, exp, act);
            end
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat exp;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing pending, expected none actual %h",
                         $time, got);
            end else begin
                exp = pending_results.pop_front();
                compare_field("wb_value", exp.wb_value, got.wb_value);
                compare_field("wb_enable", exp.wb_enable, got.wb_enable);
                compare_field("wb_index", exp.wb_index, got.wb_index);
                compare_field("mem_address", exp.mem_address, got.mem_address);
                compare_field("access_size", exp.access_size, got.access_size);
                compare_field("mem_read", exp.mem_read, got.mem_read);
                compare_field("mem_write", exp.mem_write, got.mem_write);
                compare_field("store_data", exp.store_data, got.store_data);
                compare_field("branch_taken", exp.branch_taken, got.branch_taken);
                compare_field("next_pc", exp.next_pc, got.next_pc);
                compare_field("nullify_delay_slot", exp.nullify_delay_slot,
                              got.nullify_delay_slot);
                compare_field("unsupported", exp.unsupported, got.unsupported);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    int unsigned cycle_count = 0;

    itype_scoreboard sb = new();

    mie_issue_if  issue_if ();
    mie_result_if result_if ();

    mips64_itype_execute dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (issue_if),
        .o_result (result_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && issue_if.valid && issue_if.ready) begin
            sb.note_issue(issue_if.data);
        end
        if (i_rst_n && result_if.valid && result_if.ready) begin
            sb.check_result(result_if.data);
        end
    end

    // Receiver: cycle through always-ready, coin-flip, burst-stall and mostly-ready modes.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            case (cycle_count[9:8])
                2'd0: result_if.ready <= 1'b1;
                2'd1: result_if.ready <= 1'($urandom_range(0, 1));
                2'd2: begin
                    if (stall_left != 0) begin
                        result_if.ready <= 1'b0;
                        stall_left--;
                    end else begin
                        result_if.ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0) begin
                            stall_left = $urandom_range(1, 12);
                        end
                    end
                end
                default: result_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic send_instr(input t_in_beat b);
        issue_if.valid <= 1'b1;
        issue_if.data  <= b;
        @(posedge i_clk);
        while (!issue_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_fields(input logic [5:0] op, input logic [4:0] rt,
                               input logic [15:0] imm, input logic [25:0] ji,
                               input logic [31:0] pc, input logic [63:0] rs,
                               input logic [63:0] rtv, input logic [63:0] md);
        t_in_beat b;
        b.opcode     = op;
        b.rt_index   = rt;
        b.immediate  = imm;
        b.jump_index = ji;
        b.pc         = pc;
        b.rs_value   = rs;
        b.rt_value   = rtv;
        b.mem_data   = md;
        send_instr(b);
    endtask

    task automatic pause_issue(input int unsigned n);
        issue_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic hold_until_drained();
        issue_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            4:       return {{32{1'b1}}, $urandom};
            5:       return 64'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in_beat random_instr();
        t_in_beat b;
        if ($urandom_range(0, 15) == 0) begin
            b.opcode = 6'($urandom);
        end else begin
            b.opcode = KNOWN_OPS[$urandom_range(0, 34)];
        end
        b.rt_index = ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom);
        case ($urandom_range(0, 7))
            0:       b.immediate = 16'h0000;
            1:       b.immediate = 16'hFFFF;
            2:       b.immediate = 16'h8000;
            3:       b.immediate = 16'h7FFF;
            default: b.immediate = 16'($urandom);
        endcase
        b.jump_index = 26'($urandom);
        b.pc         = $urandom;
        b.rs_value   = pick_operand();
        b.rt_value   = ($urandom_range(0, 2) == 0) ? b.rs_value : pick_operand();
        b.mem_data   = {$urandom, $urandom};
        return b;
    endfunction

    initial begin
        int unsigned sent, burst, k;
        logic        drained;

        i_rst_n        <= 1'b0;
        issue_if.valid <= 1'b0;
        issue_if.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_fields(OP_ADDI, 5'd5, 16'h0001, '0, 32'h0000_1000,
                    64'h0000_0000_7FFF_FFFF, '0, '0);
        send_fields(OP_DADDI, 5'd6, 16'h0001, '0, 32'h0000_1004,
                    64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
        send_fields(OP_ADDIU, 5'd0, 16'h8000, '0, 32'h0000_1008,
                    64'h1234_5678_9ABC_DEF0, '0, '0);
        send_fields(OP_DADDIU, 5'd31, 16'hFFFF, '0, 32'h0000_100C, '0, '0, '0);
        send_fields(OP_SLTI, 5'd1, 16'hFFFF, '0, 32'h0000_1010,
                    64'h8000_0000_0000_0000, '0, '0);
        send_fields(OP_SLTIU, 5'd2, 16'hFFFF, '0, 32'h0000_1014,
                    64'hFFFF_FFFF_FFFF_FFFE, '0, '0);
        send_fields(OP_ANDI, 5'd3, 16'hFFFF, '0, 32'h0000_1018, '1, '0, '0);
        send_fields(OP_ORI, 5'd4, 16'hA5A5, '0, 32'h0000_101C, '0, '0, '0);
        send_fields(OP_XORI, 5'd7, 16'hFFFF, '0, 32'h0000_1020, '1, '0, '0);
        send_fields(OP_LUI, 5'd8, 16'h8000, '0, 32'h0000_1024, '1, '1, '1);
        send_fields(OP_J, 5'd9, 16'h0000, 26'h3FF_FFFF, 32'hFFFF_FFFC, '1, '0, '0);
        send_fields(OP_JAL, 5'd0, 16'h0000, 26'h000_0000, 32'h7FFF_FFFC, '0, '1, '0);
        send_fields(OP_BEQ, 5'd10, 16'h7FFF, '0, 32'h0000_2000,
                    64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '0);
        send_fields(OP_BNEL, 5'd11, 16'h0004, '0, 32'h0000_2004, '1, '1, '0);
        send_fields(OP_BLEZ, 5'd12, 16'hFFFF, '0, 32'h0000_2008, '0, '1, '0);
        send_fields(OP_BGTZL, 5'd13, 16'h8000, '0, 32'h0000_200C,
                    64'h8000_0000_0000_0000, '0, '0);
        send_fields(OP_BGTZ, 5'd14, 16'h8000, '0, 32'h0000_0000, 64'd1, '0, '0);
        send_fields(OP_LB, 5'd15, 16'h0000, '0, 32'h0000_3000, '0, '0,
                    64'hFFFF_FFFF_FFFF_FF80);
        send_fields(OP_LHU, 5'd16, 16'hFFFF, '0, 32'h0000_3004, 64'd1, '0, '1);
        send_fields(OP_LWU, 5'd17, 16'h0000, '0, 32'h0000_3008, 64'd4, '0, '1);
        send_fields(OP_LD, 5'd18, 16'h7FFF, '0, 32'h0000_300C, '1, '0,
                    64'h8000_0000_0000_0001);
        send_fields(OP_LWL, 5'd19, 16'h0001, '0, 32'h0000_3010, '0,
                    64'h0123_4567_89AB_CDEF, 64'h0000_0000_8899_AABB);
        send_fields(OP_LWR, 5'd20, 16'h0000, '0, 32'h0000_3014, 64'h1000,
                    64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_F000_0000);
        send_fields(OP_SWL, 5'd21, 16'h0002, '0, 32'h0000_3018, '0,
                    64'h0000_0000_89AB_CDEF, 64'h0000_0000_DEAD_BEEF);
        send_fields(OP_SWR, 5'd22, 16'h0003, '0, 32'h0000_301C, '0,
                    64'hFFFF_FFFF_89AB_CDEF, 64'h0000_0000_DEAD_BEEF);
        send_fields(OP_SB, 5'd23, 16'hFFFF, '0, 32'h0000_3020, '0, '1, '0);
        send_fields(OP_SD, 5'd24, 16'h0008, '0, 32'h0000_3024, '1,
                    64'h8000_0000_0000_0001, '0);
        send_fields(OP_SPECIAL, 5'd25, 16'hFFFF, 26'h3FF_FFFF, 32'hFFFF_FFFC, '1, '1, '1);
        send_fields(OP_REGIMM, 5'd26, 16'h1234, '0, 32'h0000_4000, '1, '0, '1);
        send_fields(OP_LDL, 5'd27, 16'h0003, '0, 32'h0000_4004, '0, '1, '1);
        send_fields(OP_CACHE, 5'd28, 16'h0000, '0, 32'h0000_4008, '1, '1, '0);

        sent    = 0;
        drained = 1'b0;
        while (sent < RANDOM_INSTRS) begin
            burst = $urandom_range(1, 32);
            for (k = 0; k < burst && sent < RANDOM_INSTRS; k++) begin
                send_instr(random_instr());
                sent++;
            end
            if (!drained && sent >= RANDOM_INSTRS / 2) begin
                hold_until_drained();
                drained = 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                pause_issue($urandom_range(1, 8));
            end
        end

        hold_until_drained();
        repeat (8) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
